/* hw/rtl/first_seen_value_indexer_defines.svh */
// Assertion macros shared by the first_seen_value_indexer RTL.
// Define ASSERT_OFF to compile every check out.
`ifndef FIRST_SEEN_VALUE_INDEXER_DEFINES_SVH
`define FIRST_SEEN_VALUE_INDEXER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property at each rising clock edge; skip it while reset is high.
`define FSVI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property at each rising clock edge, reset included.
`define FSVI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FSVI_ASSERT(label, clk, rst, prop, msg)
`define FSVI_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* hw/rtl/fsvi_pkg.sv */
// Shared constants and types for the first_seen_value_indexer block.
// No dependencies; compile before every other RTL file.
`default_nettype none

package fsvi_pkg;

  localparam int MAX_DISTINCT = 64;
  localparam int IDX_W        = $clog2(MAX_DISTINCT);
  localparam int CNT_W        = $clog2(MAX_DISTINCT + 1);

  localparam int VALUE_W  = 64;
  localparam int RANK_W   = 7;
  localparam int COL_W    = 13;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [VALUE_W-1:0] NEG_ZERO = 64'h8000_0000_0000_0000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOME_COLUMN        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_EXTRA_COLUMN = 2'd1;

  // table lookup answer for the request in the input register
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic             full;
    logic [CNT_W-1:0] count;
  } lkp_t;

endpackage

`default_nettype wire

/* hw/rtl/first_seen_value_indexer.sv */
// Top level of the first_seen_value_indexer block: request register, result
// register and configuration registers. Depends on fsvi_pkg, fsvi_table and
// first_seen_value_indexer_defines.svh.
//
// One row is taken per clock: busy stays low, and a request accepted with
// start high passes through the request register and then the result register,
// whose outputs are valid in the cycle in which done is high. Each result is
// shown for one cycle only; the receiver cannot stall and must take it then. The
// rate is set by the combinational parallel compare of the registered request
// against all 64 table entries; the table also appends a new value at the same
// edge, so the next row already sees it. The table needs no clearing pass after
// reset. Configuration writes are always ready and should be made while no row is in flight.
`default_nettype none
`include "first_seen_value_indexer_defines.svh"

module first_seen_value_indexer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [fsvi_pkg::VALUE_W-1:0]   value,
  input  wire logic                           last,
  output logic                                done,
  output logic [fsvi_pkg::RANK_W-1:0]         rank,
  output logic [fsvi_pkg::COL_W-1:0]          column,
  output logic                                is_new,
  output logic                                overflow,
  output logic [fsvi_pkg::RANK_W-1:0]         distinct_count,
  output logic                                last_out,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fsvi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fsvi_pkg::CFG_W-1:0]     cfg_data
);
  import fsvi_pkg::*;

  logic               req_valid;
  logic [VALUE_W-1:0] req_value;
  logic               req_last;
  lkp_t               lkp;

  logic [CFG_W-1:0]   home_column;
  logic [CFG_W-1:0]   first_extra_column;

  logic               ovf_next;
  logic [CNT_W-1:0]   rank_next;
  logic [COL_W-1:0]   column_next;
  logic [CNT_W-1:0]   count_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      home_column        <= '0;
      first_extra_column <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOME_COLUMN:        home_column        <= cfg_data;
        REG_FIRST_EXTRA_COLUMN: first_extra_column <= cfg_data;
        default: ;
      endcase
    end
  end

  // fold negative zero before it reaches the table
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_value <= (value == NEG_ZERO) ? '0 : value;
      req_last  <= last;
    end
  end

  fsvi_table u_table (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_value (req_value),
    .req_last  (req_last),
    .lkp       (lkp)
  );

  always_comb begin
    ovf_next  = !lkp.hit && lkp.full;
    if (lkp.hit) begin
      rank_next = CNT_W'(lkp.idx);
    end else if (lkp.full) begin
      rank_next = CNT_W'(MAX_DISTINCT);
    end else begin
      rank_next = lkp.count;
    end
    if (ovf_next) begin
      column_next = '0;
    end else if (rank_next == '0) begin
      column_next = COL_W'(home_column);
    end else begin
      column_next = COL_W'(first_extra_column) + COL_W'(rank_next) - COL_W'(1);
    end
    count_next = lkp.count + ((!lkp.hit && !lkp.full) ? CNT_W'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      rank           <= RANK_W'(rank_next);
      column         <= column_next;
      is_new         <= !lkp.hit;
      overflow       <= ovf_next;
      distinct_count <= RANK_W'(count_next);
      last_out       <= req_last;
    end
  end

  `FSVI_ASSERT(a_result_latency, clk, rst, (start && !busy) |-> ##2 done,
               "accepted request gave no result two cycles later")
  `FSVI_ASSERT(a_overflow_shape, clk, rst,
               (done && overflow) |-> (is_new && column == '0 &&
               rank == RANK_W'(MAX_DISTINCT)), "overflow result malformed")
  `FSVI_ASSERT(a_rank_in_count, clk, rst,
               (done && !overflow) |-> (RANK_W'(rank) < distinct_count),
               "rank not below distinct count")

endmodule

`default_nettype wire

/* hw/rtl/fsvi_table.sv */
// Table of distinct values in order of first appearance, with parallel lookup.
// Depends on fsvi_pkg and first_seen_value_indexer_defines.svh.
`default_nettype none
`include "first_seen_value_indexer_defines.svh"

module fsvi_table (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  input  wire logic [fsvi_pkg::VALUE_W-1:0] req_value,
  input  wire logic                         req_last,
  output fsvi_pkg::lkp_t                    lkp
);
  import fsvi_pkg::*;

  logic [VALUE_W-1:0]      seen [MAX_DISTINCT];
  logic [CNT_W-1:0]        count;
  logic [MAX_DISTINCT-1:0] match;
  logic [IDX_W-1:0]        hit_idx;

  // stored values are distinct, so at most one entry can match
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MAX_DISTINCT; i++) begin
      match[i] = (CNT_W'(i) < count) && (seen[i] == req_value);
      hit_idx  = hit_idx | (match[i] ? IDX_W'(i) : '0);
    end
  end

  assign lkp.hit   = |match;
  assign lkp.idx   = hit_idx;
  assign lkp.full  = (count == CNT_W'(MAX_DISTINCT));
  assign lkp.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req_valid) begin
      if (req_last) begin
        count <= '0;
      end else if (!lkp.hit && !lkp.full) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // append a new value at the fill position
  always_ff @(posedge clk) begin
    if (req_valid && !lkp.hit && !lkp.full) begin
      seen[count[IDX_W-1:0]] <= req_value;
    end
  end

  `FSVI_ASSERT(a_match_unique, clk, rst, $onehot0(match), "value matched twice in table")
  `FSVI_ASSERT(a_last_clears, clk, rst, (req_valid && req_last) |=> (count == '0),
               "table not cleared after last row")
  `FSVI_ASSERT(a_insert_counts, clk, rst,
               (req_valid && !req_last && !lkp.hit && !lkp.full) |=>
               (count == $past(count) + CNT_W'(1)), "insert did not advance count")
  `FSVI_ASSERT_ALWAYS(a_count_bound, clk, rst || (count <= CNT_W'(MAX_DISTINCT)),
                      "table count beyond depth")

endmodule

`default_nettype wire

/* verif/first_seen_value_indexer_test.sv */
// Self-checking testbench for first_seen_value_indexer: drives rows and register writes,
// predicts rank, column and flags per row with a scoreboard class, and compares every result.
// Depends on fsvi_pkg and the first_seen_value_indexer RTL.
module first_seen_value_indexer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fsvi_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_ROWS = 1620;
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic [RANK_W-1:0] rank;
    logic [COL_W-1:0]  column;
    logic              is_new;
    logic              overflow;
    logic [RANK_W-1:0] distinct_count;
    logic              last_out;
  } row_result_t;

  class rank_scoreboard;
    logic [VALUE_W-1:0] seen_values [MAX_DISTINCT];
    int                 stored;
    logic [CFG_W-1:0]   home_col;
    logic [CFG_W-1:0]   extra_col;
    row_result_t        pending_results [$];
    int                 errors;

    function new();
      stored    = 0;
      home_col  = '0;
      extra_col = CFG_W'(1);
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_HOME_COLUMN: begin
          home_col = data;
        end
        REG_FIRST_EXTRA_COLUMN: begin
          extra_col = data;
        end
        default: begin
        end
      endcase
    endfunction

    // Look the row up in the table, append it if new and the table is not full, and queue the expected result.
    function void note_row(logic [VALUE_W-1:0] raw, logic last_flag);
      row_result_t        r;
      logic [VALUE_W-1:0] key;
      int                 slot;
      key  = (raw == NEG_ZERO) ? '0 : raw;
      slot = -1;
      for (int i = 0; i < stored; i++)
        if (slot < 0 && seen_values[i] == key) slot = i;
      r.is_new   = (slot < 0);
      r.overflow = 1'b0;
      if (slot < 0) begin
        if (stored < MAX_DISTINCT) begin
          slot = stored;
          seen_values[stored] = key;
          stored++;
        end else begin
          r.overflow = 1'b1;
        end
      end
      if (r.overflow) begin
        r.rank   = RANK_W'(MAX_DISTINCT);
        r.column = '0;
      end else begin
        r.rank   = RANK_W'(slot);
        r.column = (slot == 0) ? COL_W'(home_col) : COL_W'(extra_col) + COL_W'(slot - 1);
      end
      r.distinct_count = RANK_W'(stored);
      r.last_out       = last_flag;
      if (last_flag) stored = 0;
      pending_results = {pending_results, r};
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $error("%s: expected %0h, got %0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_row(row_result_t got);
      row_result_t want;
      if (pending_results.size() == 0) begin
        $error("result strobe with no request outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("rank", 32'(want.rank), 32'(got.rank));
      compare_field("column", 32'(want.column), 32'(got.column));
      compare_field("is_new", 32'(want.is_new), 32'(got.is_new));
      compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
      compare_field("distinct_count", 32'(want.distinct_count), 32'(got.distinct_count));
      compare_field("last_out", 32'(want.last_out), 32'(got.last_out));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [VALUE_W-1:0]   value;
  logic                 last;
  logic                 done;
  logic [RANK_W-1:0]    rank;
  logic [COL_W-1:0]     column;
  logic                 is_new;
  logic                 overflow;
  logic [RANK_W-1:0]    distinct_count;
  logic                 last_out;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  rank_scoreboard sb = new();
  int             rows_sent = 0;

  first_seen_value_indexer u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .value(value), .last(last),
    .done(done), .rank(rank), .column(column), .is_new(is_new), .overflow(overflow),
    .distinct_count(distinct_count), .last_out(last_out), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin : result_monitor
    row_result_t got;
    if (!rst && done) begin
      got.rank           = rank;
      got.column         = column;
      got.is_new         = is_new;
      got.overflow       = overflow;
      got.distinct_count = distinct_count;
      got.last_out       = last_out;
      sb.check_row(got);
    end
  end

  task automatic send_row(logic [VALUE_W-1:0] v, logic lf);
    @(negedge clk);
    start <= 1'b1;
    value <= v;
    last  <= lf;
    do @(posedge clk); while (busy);
    sb.note_row(v, lf);
    rows_sent++;
  endtask

  task automatic pause(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold requests until every outstanding result has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] cfg_pick();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  // One column of rows, the final one marked last. Sequential columns mostly walk
  // through fresh values so the table fills and overflows.
  task automatic run_column(int rows, int psize, bit sequential, bit quiet);
    logic [VALUE_W-1:0] pool [128];
    logic [VALUE_W-1:0] v;
    int                 next;
    int                 r;
    next = 0;
    foreach (pool[i]) pool[i] = {$urandom, $urandom};
    for (int n = 0; n < rows; n++) begin
      r = $urandom_range(0, 31);
      if (r == 0) v = NEG_ZERO;
      else if (r == 1) v = '0;
      else if (r < 4) v = {$urandom, $urandom};
      else if (sequential) begin
        if (r < 12 && next > 0) v = pool[$urandom_range(0, next - 1)];
        else begin
          v = pool[next];
          if (next < 127) next++;
        end
      end else v = pool[$urandom_range(0, psize - 1)];
      send_row(v, n == rows - 1);
      if (!quiet) pause(gap_len());
    end
  endtask

  initial begin : stimulus
    int shape;
    rst       = 1'b1;
    start     = 1'b0;
    value     = '0;
    last      = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_HOME_COLUMN;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset register values; negative zero folds onto zero, NaN patterns match exactly
    send_row(64'h0, 1'b0);
    send_row(NEG_ZERO, 1'b0);
    send_row('1, 1'b0);
    send_row(64'h1, 1'b0);
    send_row(64'h7FF8_0000_0000_0000, 1'b0);
    send_row(64'h7FF8_0000_0000_0000, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'h1, 1'b0);
    send_row('1, 1'b1);
    send_row(NEG_ZERO, 1'b0);
    send_row(64'h0, 1'b1);
    drain();

    write_cfg(REG_HOME_COLUMN, '1);
    write_cfg(REG_FIRST_EXTRA_COLUMN, '1);
    send_row(64'h5, 1'b0);
    send_row(64'h6, 1'b0);
    send_row(64'h7, 1'b0);
    send_row(64'h5, 1'b1);
    drain();

    // writes to unused indexes must leave both registers alone
    write_cfg(REG_SPARE_A, '0);
    write_cfg(REG_SPARE_B, '0);
    send_row(64'hAAAA_5555_AAAA_5555, 1'b0);
    send_row(64'h5555_AAAA_5555_AAAA, 1'b1);
    drain();
    write_cfg(REG_HOME_COLUMN, '0);
    write_cfg(REG_FIRST_EXTRA_COLUMN, '0);
    send_row(64'h9, 1'b0);
    send_row(64'hA, 1'b1);

    // the first random column is long enough to overflow the table
    run_column(130, 128, 1'b1, 1'b0);
    while (rows_sent < TARGET_ROWS) begin
      if ($urandom_range(0, 5) == 0) begin
        drain();
        write_cfg(REG_HOME_COLUMN, cfg_pick());
        write_cfg(REG_FIRST_EXTRA_COLUMN, cfg_pick());
        if ($urandom_range(0, 3) == 0)
          write_cfg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, cfg_pick());
      end
      shape = $urandom_range(0, 9);
      if (shape == 0) run_column($urandom_range(90, 130), 128, 1'b1, $urandom_range(0, 3) == 0);
      else if (shape == 1) run_column($urandom_range(1, 40), 128, 1'b0, $urandom_range(0, 3) == 0);
      else run_column($urandom_range(1, 24), $urandom_range(1, 12), 1'b0,
                      $urandom_range(0, 3) == 0);
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("first_seen_value_indexer: match");
    end else begin
      $display("first_seen_value_indexer: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("first_seen_value_indexer: mismatch");
    $finish;
  end
endmodule
